[rtl/tcpwm_pkg.sv]
`default_nettype none

package tcpwm_pkg;

    // Default build values for the top-level parameters
    localparam int DEF_TICKS_PER_SECOND = 1000;
    localparam int DEF_SECONDS_PER_DAY  = 86400;
    localparam int DEF_CHANNELS         = 2;

    // Number of PWM channels the ports and registers provide
    localparam int MAX_CHANNELS = 2;

    // Field widths
    localparam int MODE_W     = 3;
    localparam int WORD_W     = 32;
    localparam int PERIOD_W   = 16;
    localparam int DUTY_W     = 7;
    localparam int PROD_W     = PERIOD_W + DUTY_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_TICK       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ_DELTA = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ_CLOCK = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_CLOCK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RESET      = 3'd4;

    // Register map: three registers per channel
    localparam int CFG_ENABLE   = 0;
    localparam int CFG_PERIOD   = 1;
    localparam int CFG_DUTY     = 2;
    localparam int CFG_PER_CHAN = 3;

    // Duty is given in percent; divide by 100 as multiply and shift.
    // Exact for every product of a 16-bit period and a duty up to 100.
    localparam logic [DUTY_W-1:0] DUTY_MAX  = 7'd100;
    localparam int                PCT_SHIFT = 30;
    localparam logic [23:0]       PCT_RECIP = 24'd10737419;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] set_value;
    } in_item_t;

    typedef struct packed {
        logic              reply_valid;
        logic [WORD_W-1:0] reply_value;
        logic [WORD_W-1:0] tick_count;
        logic              chan0_level;
        logic              chan1_level;
    } out_item_t;

    // Clamp a duty setting to one hundred percent
    function automatic logic [DUTY_W-1:0] duty_clamp(input logic [DUTY_W-1:0] duty);
        return (duty > DUTY_MAX) ? DUTY_MAX : duty;
    endfunction

endpackage

`default_nettype wire

[rtl/tick_clock_with_pwm_unit.sv]
`default_nettype none

// Tick clock with two PWM channels.
// Pipeline: a request passes through the input register, then the result register.
// Throughput: one request per cycle while the result register is free; a stalled
// result (m_ready low) holds the input stage. The counters update in a single pass in the
// result stage, and the set-value reduction splits its multiplies across both stages.
// Reset: synchronous active-low aresetn clears counters, levels, config and valid flags.
module tick_clock_with_pwm_unit
    import tcpwm_pkg::*;
#(
    parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND,
    parameter int SECONDS_PER_DAY  = DEF_SECONDS_PER_DAY,
    parameter int CHANNELS         = DEF_CHANNELS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_item_t               s_payload,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_item_t                   m_payload,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    // Day length and the reciprocal used to reduce a set value modulo the day
    localparam longint unsigned DAY   = longint'(TICKS_PER_SECOND) * longint'(SECONDS_PER_DAY);
    localparam int              DAY_W = (DAY > 1) ? $clog2(DAY) : 1;
    localparam longint unsigned QMAX  = 64'hFFFF_FFFF / DAY;
    localparam int              Q_W   = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
    localparam longint unsigned RECIP = 64'h1_0000_0000 / DAY;

    // Configuration registers
    logic                enable_reg [MAX_CHANNELS];
    logic [PERIOD_W-1:0] period_reg [MAX_CHANNELS];
    logic [DUTY_W-1:0]   duty_reg   [MAX_CHANNELS];
    logic [PROD_W-1:0]   prod_reg   [MAX_CHANNELS];

    // Input stage
    logic                in_valid_reg;
    in_item_t            in_item_reg;
    logic [Q_W-1:0]      quot_reg;
    logic [PERIOD_W-1:0] high_reg   [MAX_CHANNELS];

    // Block state
    logic [WORD_W-1:0]   ticks_reg;
    logic [WORD_W-1:0]   delta_reg;
    logic [DAY_W-1:0]    day_clock_reg;
    logic [PERIOD_W-1:0] cnt_reg    [MAX_CHANNELS];
    logic                level_reg  [MAX_CHANNELS];

    // Result stage
    logic                m_valid_reg;
    out_item_t           m_payload_reg;

    logic                out_free;
    logic                advance;
    logic [63:0]         quot_prod;
    logic [PERIOD_W-1:0] high_next  [MAX_CHANNELS];

    logic [63:0]         qd_prod;
    logic [WORD_W-1:0]   rem_raw;
    logic [WORD_W-1:0]   rem_fix;
    logic [WORD_W-1:0]   ticks_next;
    logic [WORD_W-1:0]   delta_base;
    logic [WORD_W-1:0]   delta_next;
    logic [DAY_W-1:0]    day_base;
    logic [DAY_W-1:0]    day_next;
    logic [PERIOD_W-1:0] cnt_next   [MAX_CHANNELS];
    logic                level_next [MAX_CHANNELS];
    logic                reply_valid;
    logic [WORD_W-1:0]   reply_value;

    // Handshake: the input stage moves on when the result register is free
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Write configuration; keep period times duty ready for the high time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
                enable_reg[ch] <= 1'b0;
                period_reg[ch] <= '0;
                duty_reg[ch]   <= '0;
                prod_reg[ch]   <= '0;
            end
        end else if (cfg_we) begin
            for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
                if (cfg_index == CFG_INDEX_W'(ch * CFG_PER_CHAN + CFG_ENABLE)) begin
                    enable_reg[ch] <= cfg_wdata[0];
                end
                if (cfg_index == CFG_INDEX_W'(ch * CFG_PER_CHAN + CFG_PERIOD)) begin
                    period_reg[ch] <= cfg_wdata[PERIOD_W-1:0];
                    prod_reg[ch]   <= PROD_W'(cfg_wdata[PERIOD_W-1:0])
                                      * PROD_W'(duty_reg[ch]);
                end
                if (cfg_index == CFG_INDEX_W'(ch * CFG_PER_CHAN + CFG_DUTY)) begin
                    duty_reg[ch] <= duty_clamp(cfg_wdata[DUTY_W-1:0]);
                    prod_reg[ch] <= PROD_W'(period_reg[ch])
                                    * PROD_W'(duty_clamp(cfg_wdata[DUTY_W-1:0]));
                end
            end
        end
    end

    // Estimate the day quotient of the set value and the PWM high times
    always_comb begin
        quot_prod = 64'(s_payload.set_value) * 64'(RECIP);
        for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            high_next[ch] = PERIOD_W'((48'(prod_reg[ch]) * 48'(PCT_RECIP)) >> PCT_SHIFT);
        end
    end

    // Capture the request in the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_payload;
            quot_reg    <= quot_prod[32 +: Q_W];
            for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
                high_reg[ch] <= high_next[ch];
            end
        end
    end

    // Finish the set-value reduction: the estimate is low by at most one
    always_comb begin
        qd_prod = 64'(quot_reg) * 64'(DAY);
        rem_raw = in_item_reg.set_value - qd_prod[WORD_W-1:0];
        rem_fix = (rem_raw >= WORD_W'(DAY)) ? rem_raw - WORD_W'(DAY) : rem_raw;
    end

    // Serve the request, then advance delta and the day clock
    always_comb begin
        ticks_next  = ticks_reg + 32'd1;
        delta_base  = delta_reg;
        day_base    = day_clock_reg;
        reply_valid = 1'b0;
        reply_value = '0;
        case (in_item_reg.mode)
            MODE_READ_DELTA: begin
                reply_valid = 1'b1;
                reply_value = delta_reg;
                delta_base  = '0;
            end
            MODE_READ_CLOCK: begin
                reply_valid = 1'b1;
                reply_value = WORD_W'(day_clock_reg);
            end
            MODE_SET_CLOCK: begin
                day_base = DAY_W'(rem_fix);
            end
            MODE_RESET: begin
                ticks_next = '0;
                delta_base = '0;
                day_base   = '0;
            end
            default: begin
            end
        endcase
        delta_next = delta_base + 32'd1;
        day_next   = (day_base == DAY_W'(DAY - 1)) ? '0 : day_base + DAY_W'(1);
    end

    // Step each enabled channel; hold a disabled one
    always_comb begin
        for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            cnt_next[ch]   = cnt_reg[ch];
            level_next[ch] = level_reg[ch];
            if (ch < CHANNELS && enable_reg[ch]) begin
                level_next[ch] = (cnt_reg[ch] < high_reg[ch]);
                cnt_next[ch]   = (cnt_reg[ch] >= period_reg[ch]) ? '0
                                 : cnt_reg[ch] + PERIOD_W'(1);
            end
        end
    end

    // Update state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg     <= '0;
            delta_reg     <= '0;
            day_clock_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
                cnt_reg[ch]   <= '0;
                level_reg[ch] <= 1'b0;
            end
        end else begin
            if (out_free) begin
                m_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                ticks_reg     <= ticks_next;
                delta_reg     <= delta_next;
                day_clock_reg <= day_next;
                for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
                    cnt_reg[ch]   <= cnt_next[ch];
                    level_reg[ch] <= level_next[ch];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_payload_reg.reply_valid <= reply_valid;
            m_payload_reg.reply_value <= reply_value;
            m_payload_reg.tick_count  <= ticks_next;
            m_payload_reg.chan0_level <= level_next[0];
            m_payload_reg.chan1_level <= level_next[1];
        end
    end

    // The day clock never leaves one day
    assert property (@(posedge aclk) disable iff (!aresetn)
        WORD_W'(day_clock_reg) < WORD_W'(DAY))
        else $error("day clock outside one day");

    // A counter reset request reports a zero tick count
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_item_reg.mode == MODE_RESET |=> m_payload.tick_count == '0)
        else $error("tick count not cleared by reset request");

    // Only read requests carry a reply
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !(in_item_reg.mode == MODE_READ_DELTA
                     || in_item_reg.mode == MODE_READ_CLOCK)
        |=> !m_payload.reply_valid && m_payload.reply_value == '0)
        else $error("reply on a request that reads nothing");

    // A stalled result stage holds the request in the input stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_item_reg))
        else $error("input stage lost a stalled request");

endmodule

`default_nettype wire
